FILE: hdl/rrq_pkg.sv
// Shared types, command and register codes, and the slice interval function
// of the round-robin run queue. No dependencies.
package rrq_pkg;

	localparam int TASK_W  = 5;
	localparam int FAULT_W = 20;
	localparam int COUNT_W = 6;
	localparam int LVL_W   = 4;
	localparam int SLICE_W = 8;

	// Command codes.
	localparam logic [2:0] CMD_ENQ_TAIL = 3'd0;
	localparam logic [2:0] CMD_ENQ_HEAD = 3'd1;
	localparam logic [2:0] CMD_DEQUEUE  = 3'd2;
	localparam logic [2:0] CMD_YIELD    = 3'd3;
	localparam logic [2:0] CMD_PICK     = 3'd4;
	localparam logic [2:0] CMD_TICK     = 3'd5;
	localparam logic [2:0] CMD_QUERY    = 3'd6;

	// Register indexes.
	localparam logic [2:0] CFG_INITIAL_SLICE = 3'd0;
	localparam logic [2:0] CFG_SLICE_MAX     = 3'd1;
	localparam logic [2:0] CFG_SLICE_STEP    = 3'd2;
	localparam logic [2:0] CFG_RACE_SCALE    = 3'd3;
	localparam logic [2:0] CFG_RACE_KNEE     = 3'd4;

	localparam logic [7:0]  RST_INITIAL_SLICE = 8'd10;
	localparam logic [7:0]  RST_SLICE_MAX     = 8'd100;
	localparam logic [4:0]  RST_SLICE_STEP    = 5'd9;
	localparam logic [3:0]  RST_RACE_SCALE    = 4'd11;
	localparam logic [15:0] RST_RACE_KNEE     = 16'd2000;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [TASK_W-1:0]  task_id;
		logic [FAULT_W-1:0] fault_count;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0]  task_out;
		logic               found;
		logic               resched;
		logic [SLICE_W-1:0] slice_out;
		logic [COUNT_W-1:0] queue_count;
		logic               error;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0]  initial_slice;
		logic [7:0]  slice_max;
		logic [4:0]  slice_step;
		logic [3:0]  race_scale;
		logic [15:0] race_knee;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [3:0]         scale;
		logic [FAULT_W-1:0] fault;
		logic [15:0]        knee;
	} race_req_t;

	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] level;
	} race_rsp_t;

	// Slice granted at a given race level; saturates at one.
	function automatic logic [SLICE_W-1:0] rrq_interval(input logic [7:0] smax,
			input logic [4:0] step, input logic [LVL_W-1:0] lvl);
		logic [8:0] red;
		red = 9'(step) * 9'(lvl);
		if (red >= {1'b0, smax})
			return 8'd1;
		return smax - red[7:0];
	endfunction

endpackage

FILE: hdl/rrq_stream_if.sv
// Valid/ready channel used for requests, results and register writes.
// The payload type is chosen per instance; no package dependency.
interface rrq_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/round_robin_race_aware_quantum_unit.sv
// Channel  Direction  Payload                                          Taken when
// req      in         cmd, task_id, fault_count                        req.valid & req.ready
// rsp      out        task_out, found, resched, slice_out,             rsp.valid & rsp.ready
//                     queue_count, error
// cfg      in         index, value                                     cfg.valid & cfg.ready
//
// One request at a time: req.ready is high only in the idle state, so a new request
// is taken only after the last one has written back and registered its result.
// Each command runs as a sequence of steps, shaped by the record memory's single
// write port (one write per step) and the race level divider.
// After reset a clearing pass sweeps every slot of the record memory;
// req.ready stays low meanwhile, cfg writes are taken as usual.
// A stalled result sits in the output register while the next request is taken.
// Top level of the run queue: register bank, race level unit and sequencer.
// Depends on rrq_pkg, rrq_stream_if, rrq_cfg, rrq_race and rrq_seq.
module round_robin_race_aware_quantum_unit #(
	parameter int MAX_TASKS  = 32,
	parameter int FAULT_BITS = 20
) (
	input logic          clk,
	input logic          arst_n,
	rrq_stream_if.sink   req,
	rrq_stream_if.source rsp,
	rrq_stream_if.sink   cfg
);
	import rrq_pkg::*;

	cfg_t      regs;
	race_req_t race_req;
	race_rsp_t race_rsp;

	rrq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rrq_race #(
		.FAULT_BITS (FAULT_BITS)
	) u_race (
		.clk      (clk),
		.arst_n   (arst_n),
		.race_req (race_req),
		.race_rsp (race_rsp)
	);

	rrq_seq #(
		.MAX_TASKS (MAX_TASKS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.regs     (regs),
		.race_req (race_req),
		.race_rsp (race_rsp)
	);

`ifndef ASSERT_OFF
	a_race_latency: assert property (@(posedge clk) disable iff (!arst_n)
		race_req.start |-> ##5 race_rsp.done)
		else $error("race level result did not arrive five cycles after start");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.found |-> !rsp.data.error && !rsp.data.resched)
		else $error("pick result flagged error or reschedule");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.error |-> rsp.data.slice_out == '0 && !rsp.data.found)
		else $error("rejected request returned a slice or a found task");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.data.queue_count) <= 32'(MAX_TASKS))
		else $error("queue count exceeds the number of task slots");
`endif

endmodule

FILE: hdl/rrq_race.sv
// Race level unit: scale*f / (f + knee), the product registered at start, then a four-step
// restoring divider. Depends on rrq_pkg.
module rrq_race #(
	parameter int FAULT_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrq_pkg::race_req_t  race_req,
	output rrq_pkg::race_rsp_t  race_rsp
);
	import rrq_pkg::*;

	localparam int FW = (FAULT_BITS < FAULT_W) ? FAULT_BITS : FAULT_W;
	localparam int NW = FW + 4;
	localparam int DW = ((FW > 16) ? FW : 16) + 1;
	localparam int CW = DW + 3;

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_DIV  = 3'b010,
		R_DONE = 3'b100
	} race_state_t;

	race_state_t      state_q;
	logic [1:0]       cnt_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dsh_q;
	logic [LVL_W-1:0] quo_q;
	logic             dz_q;

	logic [FW-1:0] f_eff;
	logic [NW-1:0] prod;
	logic [DW-1:0] den;
	logic          ge;

	assign f_eff = race_req.fault[FW-1:0];
	assign prod  = NW'(race_req.scale) * NW'(f_eff);
	assign den   = DW'(f_eff) + DW'(race_req.knee);
	assign ge    = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (race_req.start) begin
						state_q <= R_DIV;
						cnt_q   <= 2'd3;
					end
				end
				R_DIV: begin
					if (cnt_q == 2'd0)
						state_q <= R_DONE;
					else
						cnt_q <= cnt_q - 2'd1;
				end
				R_DONE: state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// The quotient never exceeds the scale, so four quotient bits suffice.
	always_ff @(posedge clk) begin
		if (state_q == R_IDLE && race_req.start) begin
			rem_q <= CW'(prod);
			dsh_q <= {den, 3'b000};
			dz_q  <= (den == '0);
			quo_q <= '0;
		end else if (state_q == R_DIV) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[LVL_W-2:0], ge};
		end
	end

	assign race_rsp.done  = (state_q == R_DONE);
	assign race_rsp.level = dz_q ? '0 : quo_q;

endmodule

FILE: hdl/rrq_cfg.sv
// Configuration register bank of the run queue, written over its own channel.
// Depends on rrq_pkg and rrq_stream_if.
module rrq_cfg (
	input  logic          clk,
	input  logic          arst_n,
	rrq_stream_if.sink    cfg,
	output rrq_pkg::cfg_t regs
);
	import rrq_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.initial_slice <= RST_INITIAL_SLICE;
			regs_q.slice_max     <= RST_SLICE_MAX;
			regs_q.slice_step    <= RST_SLICE_STEP;
			regs_q.race_scale    <= RST_RACE_SCALE;
			regs_q.race_knee     <= RST_RACE_KNEE;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_INITIAL_SLICE: regs_q.initial_slice <= cfg.data.value[7:0];
				CFG_SLICE_MAX:     regs_q.slice_max     <= cfg.data.value[7:0];
				CFG_SLICE_STEP:    regs_q.slice_step    <= cfg.data.value[4:0];
				CFG_RACE_SCALE:    regs_q.race_scale    <= cfg.data.value[3:0];
				CFG_RACE_KNEE:     regs_q.race_knee     <= cfg.data.value[15:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/rrq_seq.sv
// Command sequencer of the run queue: task record memory, head/tail/count,
// link and unlink steps, and the result register. Depends on rrq_pkg and rrq_stream_if.
module rrq_seq #(
	parameter int MAX_TASKS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	rrq_stream_if.sink         req,
	rrq_stream_if.source       rsp,
	input  rrq_pkg::cfg_t      regs,
	output rrq_pkg::race_req_t race_req,
	input  rrq_pkg::race_rsp_t race_rsp
);
	import rrq_pkg::*;

	localparam int ID_W  = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic               queued;
		logic [LVL_W-1:0]   level;
		logic [SLICE_W-1:0] slice;
		logic [ID_W-1:0]    prv;
		logic [ID_W-1:0]    nxt;
	} rec_t;

	typedef struct packed {
		logic queued;
		logic level;
		logic slice;
		logic prv;
		logic nxt;
	} rec_en_t;

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_EXEC     = 10'b0000000100,
		S_RACE     = 10'b0000001000,
		S_UNL_P    = 10'b0000010000,
		S_UNL_N    = 10'b0000100000,
		S_UNL_SELF = 10'b0001000000,
		S_LINK_NB  = 10'b0010000000,
		S_SELF_WR  = 10'b0100000000,
		S_DONE     = 10'b1000000000
	} seq_state_t;

	// Task record memory, one read and one write port.
	rec_t            mem [MAX_TASKS];
	rec_t            mem_rd_q;
	logic            mem_we;
	logic [ID_W-1:0] mem_waddr;
	logic [ID_W-1:0] mem_raddr;
	rec_t            mem_wdata;
	rec_en_t         mem_wen;

	seq_state_t          state_q;
	seq_state_t          exec_next;
	logic [ID_W-1:0]     clr_q;
	logic [ID_W-1:0]     head_q;
	logic [ID_W-1:0]     tail_q;
	logic [CNT_W-1:0]    count_q;
	logic                ov_q;

	logic [2:0]          cmd_q;
	logic [TASK_W-1:0]   tid_q;
	logic [FAULT_W-1:0]  fault_q;
	logic [ID_W-1:0]     prv_q;
	logic [ID_W-1:0]     nxt_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [SLICE_W-1:0]  sl_q;
	logic [TASK_W-1:0]   res_task_q;
	logic                res_found_q;
	logic                res_resched_q;
	logic                res_err_q;
	rsp_t                out_q;

	logic [ID_W-1:0] idx;
	logic            id_ok;
	logic            tick_exp;
	logic            out_free;

	assign idx      = ID_W'(tid_q);
	assign id_ok    = (32'(tid_q) < 32'(MAX_TASKS));
	assign tick_exp = (mem_rd_q.slice == 8'd1);
	assign out_free = !ov_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.data  = out_q;

	assign mem_raddr = (req.data.cmd == CMD_PICK) ? head_q : ID_W'(req.data.task_id);

	assign race_req.start = (state_q == S_EXEC) && (cmd_q == CMD_TICK) && id_ok
		&& mem_rd_q.queued && tick_exp;
	assign race_req.scale = regs.race_scale;
	assign race_req.fault = fault_q;
	assign race_req.knee  = regs.race_knee;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (mem_wen.queued) mem[mem_waddr].queued <= mem_wdata.queued;
			if (mem_wen.level)  mem[mem_waddr].level  <= mem_wdata.level;
			if (mem_wen.slice)  mem[mem_waddr].slice  <= mem_wdata.slice;
			if (mem_wen.prv)    mem[mem_waddr].prv    <= mem_wdata.prv;
			if (mem_wen.nxt)    mem[mem_waddr].nxt    <= mem_wdata.nxt;
		end
		mem_rd_q <= mem[mem_raddr];
	end

	// Each step issues at most one write; the read for the next request comes
	// only after the previous request has written everything back.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx;
		mem_wdata = '0;
		mem_wen   = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wen   = '1;
			end
			S_UNL_P: begin
				mem_we        = (idx != head_q);
				mem_waddr     = prv_q;
				mem_wdata.nxt = nxt_q;
				mem_wen.nxt   = 1'b1;
			end
			S_UNL_N: begin
				mem_we        = (idx != tail_q);
				mem_waddr     = nxt_q;
				mem_wdata.prv = prv_q;
				mem_wen.prv   = 1'b1;
			end
			S_UNL_SELF: begin
				mem_we         = 1'b1;
				mem_wen.queued = 1'b1;
			end
			S_LINK_NB: begin
				mem_we = (count_q != '0);
				if (cmd_q == CMD_ENQ_HEAD) begin
					mem_waddr     = head_q;
					mem_wdata.prv = idx;
					mem_wen.prv   = 1'b1;
				end else begin
					mem_waddr     = tail_q;
					mem_wdata.nxt = idx;
					mem_wen.nxt   = 1'b1;
				end
			end
			S_SELF_WR: begin
				mem_we           = 1'b1;
				mem_wen          = '1;
				mem_wdata.queued = 1'b1;
				mem_wdata.level  = lvl_q;
				mem_wdata.slice  = sl_q;
				mem_wdata.prv    = prv_q;
				mem_wdata.nxt    = nxt_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		exec_next = S_DONE;
		if (id_ok) begin
			unique case (cmd_q) inside
				CMD_ENQ_TAIL, CMD_ENQ_HEAD: begin
					if (!mem_rd_q.queued)
						exec_next = S_LINK_NB;
				end
				CMD_DEQUEUE, CMD_YIELD: begin
					if (mem_rd_q.queued)
						exec_next = S_UNL_P;
				end
				CMD_TICK: begin
					if (mem_rd_q.queued)
						exec_next = tick_exp ? S_RACE : S_SELF_WR;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ID_W'(1);
					if (clr_q == ID_W'(MAX_TASKS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid)
						state_q <= S_EXEC;
				end
				S_EXEC: state_q <= exec_next;
				S_RACE: begin
					if (race_rsp.done)
						state_q <= (count_q > CNT_W'(1)) ? S_UNL_P : S_SELF_WR;
				end
				S_UNL_P: begin
					if (idx == head_q)
						head_q <= nxt_q;
					state_q <= S_UNL_N;
				end
				S_UNL_N: begin
					if (idx == tail_q)
						tail_q <= prv_q;
					count_q <= count_q - CNT_W'(1);
					// The queue empties: both pointers return to slot zero.
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end
					state_q <= (cmd_q == CMD_DEQUEUE) ? S_UNL_SELF : S_LINK_NB;
				end
				S_UNL_SELF: state_q <= S_DONE;
				S_LINK_NB: begin
					if (count_q == '0) begin
						head_q <= idx;
						tail_q <= idx;
					end else if (cmd_q == CMD_ENQ_HEAD) begin
						head_q <= idx;
					end else begin
						tail_q <= idx;
					end
					count_q <= count_q + CNT_W'(1);
					state_q <= S_SELF_WR;
				end
				S_SELF_WR: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= req.data.cmd;
				tid_q   <= req.data.task_id;
				fault_q <= req.data.fault_count;
			end
			S_EXEC: begin
				prv_q         <= mem_rd_q.prv;
				nxt_q         <= mem_rd_q.nxt;
				lvl_q         <= mem_rd_q.level;
				sl_q          <= '0;
				res_task_q    <= tid_q;
				res_found_q   <= 1'b0;
				res_resched_q <= 1'b0;
				res_err_q     <= 1'b0;
				if (cmd_q == CMD_PICK) begin
					if (count_q != '0) begin
						res_task_q  <= TASK_W'(head_q);
						res_found_q <= 1'b1;
						sl_q        <= mem_rd_q.slice;
					end else begin
						res_task_q <= '0;
					end
				end else if (!id_ok) begin
					res_err_q <= (cmd_q <= CMD_QUERY);
				end else begin
					unique case (cmd_q) inside
						CMD_ENQ_TAIL, CMD_ENQ_HEAD: begin
							if (mem_rd_q.queued)
								res_err_q <= 1'b1;
							else
								sl_q <= regs.initial_slice;
						end
						CMD_DEQUEUE, CMD_YIELD: begin
							if (!mem_rd_q.queued)
								res_err_q <= 1'b1;
							else
								sl_q <= mem_rd_q.slice;
						end
						CMD_TICK: begin
							// A zero slice wraps to 255 and does not expire.
							if (!mem_rd_q.queued)
								res_err_q <= 1'b1;
							else
								sl_q <= mem_rd_q.slice - 8'd1;
						end
						CMD_QUERY: begin
							sl_q <= rrq_interval(regs.slice_max, regs.slice_step,
								mem_rd_q.level);
						end
						default: ;
					endcase
				end
			end
			S_RACE: begin
				if (race_rsp.done) begin
					lvl_q         <= race_rsp.level;
					sl_q          <= rrq_interval(regs.slice_max, regs.slice_step,
						race_rsp.level);
					res_resched_q <= (count_q > CNT_W'(1));
				end
			end
			S_LINK_NB: begin
				if (count_q == '0) begin
					prv_q <= idx;
					nxt_q <= idx;
				end else if (cmd_q == CMD_ENQ_HEAD) begin
					prv_q <= idx;
					nxt_q <= head_q;
				end else begin
					prv_q <= tail_q;
					nxt_q <= idx;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q.task_out    <= res_task_q;
					out_q.found       <= res_found_q;
					out_q.resched     <= res_resched_q;
					out_q.slice_out   <= sl_q;
					out_q.queue_count <= COUNT_W'(count_q);
					out_q.error       <= res_err_q;
				end
			end
			default: ;
		endcase
	end

endmodule
